>>> sv/dbls_pkg.sv
`default_nettype none

package dbls_pkg;

    // Grid geometry
    localparam int GRID_COLS = 320;
    localparam int GRID_ROWS = 180;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    // Coordinates and Bresenham error term
    localparam int COORD_W = 11;
    localparam int PT_W    = COORD_W + 1;
    localparam int ERR_W   = COORD_W + 3;

    // Brush
    localparam int RAD_W        = 5;
    localparam int RADIUS_MAX   = 25;
    localparam int RADIUS_RESET = 1;
    localparam int OFS_W        = $clog2(RADIUS_MAX + 1) + 1;
    localparam int RSQ_W        = $clog2(RADIUS_MAX * RADIUS_MAX + 1);
    localparam int SQ_W         = RSQ_W + 1;

    // Cell codes and tools
    localparam int CODE_W = 2;
    localparam int TOOL_W = 2;
    localparam logic [CODE_W-1:0] CODE_AIR   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_WATER = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SOLID = 2'd2;
    localparam logic [TOOL_W-1:0] BRUSH_WATER = 2'd0;
    localparam logic [TOOL_W-1:0] BRUSH_SOLID = 2'd1;
    localparam logic [TOOL_W-1:0] BRUSH_ERASE = 2'd2;
    localparam logic [TOOL_W-1:0] BRUSH_NONE  = 2'd3;
    localparam logic OP_STROKE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // Command queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_STROKE,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [ERR_W-1:0]   dx_pos;
        logic signed [ERR_W-1:0]   dy_neg;
        logic                      step_x_pos;
        logic                      step_y_pos;
        logic [CODE_W-1:0]         code;
        logic [RAD_W-1:0]          radius;
        logic [RSQ_W-1:0]          rsq;
        logic [ADDR_W-1:0]         rd_addr;
        logic                      rd_on_grid;
    } cmd_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_STAMP,
        B_STEP,
        B_DONE
    } back_state_t;

    function automatic logic on_grid(input logic signed [PT_W-1:0] px,
                                     input logic signed [PT_W-1:0] py);
        return (px >= 0) && (px < $signed(PT_W'(GRID_COLS)))
            && (py >= 0) && (py < $signed(PT_W'(GRID_ROWS)));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(col) + ADDR_W'(ADDR_W'(GRID_COLS) * ADDR_W'(row));
    endfunction

endpackage

`default_nettype wire

>>> sv/dbls_front.sv
`default_nettype none

module dbls_front import dbls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [RAD_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 fifo_full,
    input  logic                 engine_clearing,
    output logic                 push,
    output cmd_t                 cmd
);

    logic [RAD_W-1:0]          brush_radius_reg, brush_radius_next;
    logic signed [COORD_W-1:0] x0, y0, x1, y1;
    logic [TOOL_W-1:0]         tool;
    logic signed [PT_W-1:0]    ax, ay, adx, ady, px0, py0;

    // radius saturates on write
    always_comb begin
        brush_radius_next = brush_radius_reg;
        if (cfg_wr_en) begin
            brush_radius_next = (cfg_wr_data > RAD_W'(RADIUS_MAX)) ?
                                RAD_W'(RADIUS_MAX) : cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brush_radius_reg <= RAD_W'(RADIUS_RESET);
        end else begin
            brush_radius_reg <= brush_radius_next;
        end
    end

    assign x0   = $signed(s_tdata[COORD_W-1:0]);
    assign y0   = $signed(s_tdata[2*COORD_W-1:COORD_W]);
    assign x1   = $signed(s_tdata[3*COORD_W-1:2*COORD_W]);
    assign y1   = $signed(s_tdata[4*COORD_W-1:3*COORD_W]);
    assign tool = s_tdata[4*COORD_W+TOOL_W-1:4*COORD_W];

    assign ax  = $signed({x1[COORD_W-1], x1}) - $signed({x0[COORD_W-1], x0});
    assign ay  = $signed({y1[COORD_W-1], y1}) - $signed({y0[COORD_W-1], y0});
    assign adx = (ax < 0) ? -ax : ax;
    assign ady = (ay < 0) ? ay : -ay;
    assign px0 = $signed({x0[COORD_W-1], x0});
    assign py0 = $signed({y0[COORD_W-1], y0});

    always_comb begin
        if (s_tuser == OP_READ) begin
            cmd.kind = CMD_READ;
        end else if (tool == BRUSH_NONE) begin
            cmd.kind = CMD_NOP;
        end else begin
            cmd.kind = CMD_STROKE;
        end
        cmd.x0         = x0;
        cmd.y0         = y0;
        cmd.x1         = x1;
        cmd.y1         = y1;
        cmd.dx_pos     = ERR_W'(adx);
        cmd.dy_neg     = ERR_W'(ady);
        cmd.step_x_pos = x0 < x1;
        cmd.step_y_pos = y0 < y1;
        unique case (tool) inside
            BRUSH_WATER:             cmd.code = CODE_WATER;
            BRUSH_SOLID:             cmd.code = CODE_SOLID;
            BRUSH_ERASE, BRUSH_NONE: cmd.code = CODE_AIR;
        endcase
        cmd.radius     = brush_radius_reg;
        cmd.rsq        = RSQ_W'(RSQ_W'(brush_radius_reg) * RSQ_W'(brush_radius_reg));
        cmd.rd_on_grid = on_grid(px0, py0);
        cmd.rd_addr    = cell_addr(px0[COL_W-1:0], py0[ROW_W-1:0]);
    end

    assign s_tready = !fifo_full && !engine_clearing;
    assign push     = s_tvalid && s_tready;

endmodule

`default_nettype wire

>>> sv/dbls_cmd_fifo.sv
`default_nettype none

module dbls_cmd_fifo import dbls_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t cmd_out,
    output logic full,
    output logic empty
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command queue read while empty");

endmodule

`default_nettype wire

>>> sv/dbls_back.sv
`default_nettype none

module dbls_back import dbls_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fifo_empty,
    input  cmd_t              fifo_cmd,
    output logic              fifo_pop,
    output logic              clearing,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CODE_W-1:0] m_code,
    output logic              m_is_read
);

    back_state_t               state_reg, state_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [OFS_W-1:0]   dxo_reg, dxo_next, dyo_reg, dyo_next;
    logic                      wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]         wr_addr_reg, wr_addr_next;
    logic [CODE_W-1:0]         wr_code_reg, wr_code_next;
    logic                      m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]         m_code_reg, m_code_next;
    logic                      m_read_reg, m_read_next;
    logic [CODE_W-1:0]         rd_data_reg;

    logic [CODE_W-1:0]         grid_ram [CELLS];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_addr;
    logic [CODE_W-1:0]         mem_wdata;

    logic signed [OFS_W-1:0]   r_s, fifo_r_s;
    logic signed [PT_W-1:0]    px, py;
    logic signed [2*OFS_W-1:0] prod_x, prod_y;
    logic [SQ_W-1:0]           dsum;
    logic                      in_disc, disc_on_grid;
    logic [ADDR_W-1:0]         disc_addr;
    logic signed [ERR_W:0]     e2, dx_ext, dy_ext;
    logic                      step_x, step_y;
    logic signed [ERR_W-1:0]   err_a, err_b;

    // disc raster point
    assign r_s          = $signed(OFS_W'(cmd_reg.radius));
    assign fifo_r_s     = $signed(OFS_W'(fifo_cmd.radius));
    assign px           = $signed({x_reg[COORD_W-1], x_reg}) + PT_W'(dxo_reg);
    assign py           = $signed({y_reg[COORD_W-1], y_reg}) + PT_W'(dyo_reg);
    assign prod_x       = dxo_reg * dxo_reg;
    assign prod_y       = dyo_reg * dyo_reg;
    assign dsum         = SQ_W'(prod_x[RSQ_W-1:0]) + SQ_W'(prod_y[RSQ_W-1:0]);
    assign in_disc      = dsum <= SQ_W'(cmd_reg.rsq);
    assign disc_on_grid = on_grid(px, py);
    assign disc_addr    = cell_addr(px[COL_W-1:0], py[ROW_W-1:0]);

    // Bresenham step
    assign e2     = $signed({err_reg, 1'b0});
    assign dx_ext = $signed({cmd_reg.dx_pos[ERR_W-1], cmd_reg.dx_pos});
    assign dy_ext = $signed({cmd_reg.dy_neg[ERR_W-1], cmd_reg.dy_neg});
    assign step_x = e2 >= dy_ext;
    assign step_y = e2 <= dx_ext;
    assign err_a  = step_x ? err_reg + cmd_reg.dy_neg : err_reg;
    assign err_b  = step_y ? err_a + cmd_reg.dx_pos : err_a;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        err_next      = err_reg;
        dxo_next      = dxo_reg;
        dyo_next      = dyo_reg;
        wr_en_next    = 1'b0;
        wr_addr_next  = disc_addr;
        wr_code_next  = cmd_reg.code;
        m_valid_next  = m_valid_reg && !m_ready;
        m_code_next   = m_code_reg;
        m_read_next   = m_read_reg;
        fifo_pop      = 1'b0;
        unique case (state_reg)
            B_CLEAR: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!fifo_empty) begin
                    fifo_pop = 1'b1;
                    cmd_next = fifo_cmd;
                    x_next   = fifo_cmd.x0;
                    y_next   = fifo_cmd.y0;
                    err_next = fifo_cmd.dx_pos + fifo_cmd.dy_neg;
                    dxo_next = -fifo_r_s;
                    dyo_next = -fifo_r_s;
                    case (fifo_cmd.kind)
                        CMD_READ:   state_next = B_READ;
                        CMD_STROKE: state_next = B_STAMP;
                        default:    state_next = B_DONE;
                    endcase
                end
            end
            B_READ: begin
                state_next = B_DONE;
            end
            B_STAMP: begin
                wr_en_next = in_disc && disc_on_grid;
                if (dxo_reg == r_s) begin
                    dxo_next = -r_s;
                    if (dyo_reg == r_s) begin
                        state_next = B_STEP;
                    end else begin
                        dyo_next = dyo_reg + OFS_W'(1);
                    end
                end else begin
                    dxo_next = dxo_reg + OFS_W'(1);
                end
            end
            B_STEP: begin
                if (x_reg == cmd_reg.x1 && y_reg == cmd_reg.y1) begin
                    state_next = B_DONE;
                end else begin
                    if (step_x) begin
                        x_next = cmd_reg.step_x_pos ? x_reg + COORD_W'(1)
                                                    : x_reg - COORD_W'(1);
                    end
                    if (step_y) begin
                        y_next = cmd_reg.step_y_pos ? y_reg + COORD_W'(1)
                                                    : y_reg - COORD_W'(1);
                    end
                    err_next   = err_b;
                    dxo_next   = -r_s;
                    dyo_next   = -r_s;
                    state_next = B_STAMP;
                end
            end
            B_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_read_next  = cmd_reg.kind == CMD_READ;
                    m_code_next  = (cmd_reg.kind == CMD_READ && cmd_reg.rd_on_grid) ?
                                   rd_data_reg : CODE_AIR;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            wr_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wr_en_reg    <= wr_en_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        err_reg     <= err_next;
        dxo_reg     <= dxo_next;
        dyo_reg     <= dyo_next;
        wr_addr_reg <= wr_addr_next;
        wr_code_reg <= wr_code_next;
        m_code_reg  <= m_code_next;
        m_read_reg  <= m_read_next;
    end

    // grid storage: one write port (clear sweep or stamp), one registered read
    assign mem_we    = (state_reg == B_CLEAR) || wr_en_reg;
    assign mem_addr  = (state_reg == B_CLEAR) ? clr_addr_reg : wr_addr_reg;
    assign mem_wdata = (state_reg == B_CLEAR) ? CODE_AIR : wr_code_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_ram[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= grid_ram[cmd_reg.rd_addr];
    end

    assign clearing  = state_reg == B_CLEAR;
    assign m_valid   = m_valid_reg;
    assign m_code    = m_code_reg;
    assign m_is_read = m_read_reg;

    a_wr_from_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg |-> $past(state_reg) == B_STAMP)
        else $error("grid write without a stamp cycle");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg |-> int'(wr_addr_reg) < CELLS)
        else $error("grid write address beyond grid");

    a_quiet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_CLEAR |-> !m_valid_reg)
        else $error("result presented during clear sweep");

    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_code_reg <= CODE_SOLID)
        else $error("illegal cell code on result");

endmodule

`default_nettype wire

>>> sv/disc_brush_line_stamper_unit.sv
// Engine: one item at a time; a read passes through the idle, read and done states; a tool-3
//   stroke goes from idle straight to done; a drawing stroke stamps the (2r+1)^2 square
//   at each of P = max(|dx|,|dy|)+1 line points, with a step state between points, then
//   goes to done; at most one grid cell write per cycle.
// Reset: aresetn synchronous, active low; radius returns to 1, then a clear sweep over all
//   57600 cells zeroes the grid, with s_tready low until it ends.
`default_nettype none

module disc_brush_line_stamper_unit import dbls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // brush radius register (saturates at 25)
    input  logic                 cfg_wr_en,
    input  logic [RAD_W-1:0]     cfg_wr_data,
    // command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [10:0] start_x, [21:11] start_y, [32:22] end_x, [43:33] end_y,
    // [45:44] tool, [47:46] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] op: 0 stroke, 1 read
    input  logic                 s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] cell_code, [7:2] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] is_read_reply
    output logic                 m_tuser
);

    // Front end: holds the radius register, decodes each transaction into an
    // engine command (kind, Bresenham deltas, tool code, read address).
    logic push, fifo_full, fifo_empty, fifo_pop, clearing;
    cmd_t push_cmd, head_cmd;
    logic [CODE_W-1:0] m_code;

    dbls_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .fifo_full       (fifo_full),
        .engine_clearing (clearing),
        .push            (push),
        .cmd             (push_cmd)
    );

    // Short command queue decouples intake from the stamping engine, so new
    // transactions are taken while a long stroke is still being drawn.
    dbls_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (fifo_pop),
        .cmd_out (head_cmd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // Back end: grid RAM, clear sweep, Bresenham walker and disc raster.
    // Each line point scans the (2r+1)^2 square, writing in-disc on-grid cells.
    // The result sits in an output register, so the engine only waits on m_tready
    // when a second result is ready before the first was taken.
    dbls_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .fifo_cmd   (head_cmd),
        .fifo_pop   (fifo_pop),
        .clearing   (clearing),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_code     (m_code),
        .m_is_read  (m_tuser)
    );

    assign m_tdata = {{(M_TDATA_W - CODE_W){1'b0}}, m_code};

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

// Grid stamper check: strokes and cell reads go in over the command stream, and each
// reply is checked against a local grid model kept in step with every accepted transaction.
module tb;
    import dbls_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off, fills the command queue
    localparam int DRAIN_CYCLES = 10;      // settle time after the last reply before the verdict
    localparam int QUIET_LIMIT  = 200000;  // must outlast the clear sweep over all 57600 cells and the worst stroke
    localparam int STROKE_BUDGET = 3000;   // cycles one random stroke may roughly take

    // one command transaction, fields as they travel
    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [TOOL_W-1:0]         tool;
    } stamp_cmd_t;

    // one result transaction
    typedef struct {
        logic [CODE_W-1:0] code;
        logic              is_read;
    } cell_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [RAD_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [10:0] x0, [21:11] y0, [32:22] x1, [43:33] y1,
                                          // [45:44] tool, [47:46] zero
    logic                 s_tuser = 1'b0; // [0] op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [1:0] cell_code, [7:2] zero
    logic                 m_tuser;        // [0] is_read_reply

    disc_brush_line_stamper_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // stimulus backlog and replies still owed by the block
    stamp_cmd_t  cmd_backlog[$];
    cell_reply_t awaited_replies[$];

    // grid model and brush setting
    logic [CODE_W-1:0] cell_model[GRID_COLS*GRID_ROWS];
    logic [RAD_W-1:0]  radius_model;

    int err_count      = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_served    = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int last_x         = 0;
    int last_y         = 0;

    //------------------------------------------------------------------
    // Grid model
    //------------------------------------------------------------------
    function automatic bit cell_on_grid(int x, int y);
        return x >= 0 && x < GRID_COLS && y >= 0 && y < GRID_ROWS;
    endfunction

    function automatic void paint_disc(int cx, int cy, int r, logic [CODE_W-1:0] code);
        int ox, oy;
        for (oy = -r; oy <= r; oy++) begin
            for (ox = -r; ox <= r; ox++) begin
                if (ox * ox + oy * oy <= r * r && cell_on_grid(cx + ox, cy + oy)) begin
                    cell_model[(cx + ox) + GRID_COLS * (cy + oy)] = code;
                end
            end
        end
    endfunction

    // Bresenham walk, endpoints included, disc at every point
    function automatic void paint_stroke(stamp_cmd_t c, int r, logic [CODE_W-1:0] code);
        int x, y, xe, ye, run, rise, sx, sy, err, e2;
        x    = c.x0;
        y    = c.y0;
        xe   = c.x1;
        ye   = c.y1;
        run  = (xe > x) ? xe - x : x - xe;
        rise = (ye > y) ? y - ye : ye - y;   // kept negative
        sx   = (x < xe) ? 1 : -1;
        sy   = (y < ye) ? 1 : -1;
        err  = run + rise;
        forever begin
            paint_disc(x, y, r, code);
            if (x == xe && y == ye) break;
            e2 = 2 * err;
            if (e2 >= rise) begin
                err += rise;
                x   += sx;
            end
            if (e2 <= run) begin
                err += run;
                y   += sy;
            end
        end
    endfunction

    function automatic cell_reply_t predict_reply(stamp_cmd_t c);
        cell_reply_t rep;
        int r;
        rep.code    = CODE_AIR;
        rep.is_read = (c.op == OP_READ);
        if (c.op == OP_READ) begin
            if (cell_on_grid(c.x0, c.y0)) rep.code = cell_model[c.x0 + GRID_COLS * c.y0];
        end else if (c.tool != BRUSH_NONE) begin
            r = (radius_model > RADIUS_MAX) ? RADIUS_MAX : radius_model;
            case (c.tool)
                BRUSH_WATER: paint_stroke(c, r, CODE_WATER);
                BRUSH_SOLID: paint_stroke(c, r, CODE_SOLID);
                default:     paint_stroke(c, r, CODE_AIR);
            endcase
        end
        return rep;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    function automatic int rand_coord();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < -1024) ? -1024 : ((v > 1023) ? 1023 : v);
    endfunction

    task automatic push_stroke(int x0, int y0, int x1, int y1, logic [TOOL_W-1:0] tool);
        stamp_cmd_t c;
        c.op   = OP_STROKE;
        c.x0   = COORD_W'(x0);
        c.y0   = COORD_W'(y0);
        c.x1   = COORD_W'(x1);
        c.y1   = COORD_W'(y1);
        c.tool = tool;
        cmd_backlog.push_back(c);
    endtask

    // end point and tool are ignored by reads; fill them with noise
    task automatic push_read(int x, int y);
        stamp_cmd_t c;
        c.op   = OP_READ;
        c.x0   = COORD_W'(x);
        c.y0   = COORD_W'(y);
        c.x1   = COORD_W'(rand_coord());
        c.y1   = COORD_W'(rand_coord());
        c.tool = TOOL_W'($urandom_range(0, 3));
        cmd_backlog.push_back(c);
    endtask

    // Half reads, half strokes. Stroke length is scaled to the brush against
    // STROKE_BUDGET; reads favor the last stroke.
    task automatic queue_random_items(int count, int rad_cfg);
        int r, budget, span, reach, x0, y0, x1, y1;
        r      = (rad_cfg > RADIUS_MAX) ? RADIUS_MAX : rad_cfg;
        budget = STROKE_BUDGET / ((2 * r + 1) * (2 * r + 1) + 1);
        if (budget < 1) budget = 1;
        reach  = r + 2;
        repeat (count) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0, 1: push_read(last_x + int'($urandom_range(0, 2 * reach)) - reach,
                                    last_y + int'($urandom_range(0, 2 * reach)) - reach);
                    2, 3: push_read($urandom_range(0, GRID_COLS - 1),
                                    $urandom_range(0, GRID_ROWS - 1));
                    default: push_read(rand_coord(), rand_coord());
                endcase
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    x0 = rand_coord();
                    y0 = rand_coord();
                end else begin
                    x0 = int'($urandom_range(0, GRID_COLS + 19)) - 10;
                    y0 = int'($urandom_range(0, GRID_ROWS + 19)) - 10;
                end
                span = $urandom_range(0, budget - 1);
                if (r == 0 && $urandom_range(0, 5) == 0) begin
                    // full-range line, only affordable with a point brush
                    x1 = rand_coord();
                    y1 = rand_coord();
                end else begin
                    x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
                    y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
                end
                push_stroke(x0, y0, x1, y1, TOOL_W'($urandom_range(0, 3)));
                last_x = x0;
                last_y = y0;
            end
        end
    endtask

    // everything handed over and every reply back
    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || awaited_replies.size() != 0);
    endtask

    task automatic write_radius(int value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= RAD_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge aclk);
        send_gap_pct   <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    //------------------------------------------------------------------
    // Command driver: next transaction once the current one is taken
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        stamp_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                c = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.op;
                s_tdata  <= {2'b00, c.tool, c.y1, c.x1, c.y0, c.x0};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold on request
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_request != hold_served) begin
            hold_served = hold_request;
            stall_left  = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    //------------------------------------------------------------------
    // Monitor: track config, predict on each command, check each reply
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        stamp_cmd_t  c;
        cell_reply_t want;
        if (!aresetn) begin
            radius_model = RAD_W'(RADIUS_RESET);
            foreach (cell_model[i]) cell_model[i] = CODE_AIR;
        end else begin
            if (cfg_wr_en) radius_model = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                c.op   = s_tuser;
                c.x0   = s_tdata[10:0];
                c.y0   = s_tdata[21:11];
                c.x1   = s_tdata[32:22];
                c.y1   = s_tdata[43:33];
                c.tool = s_tdata[45:44];
                awaited_replies.push_back(predict_reply(c));
            end
            if (m_tvalid && m_tready) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected result: cell_code %0d is_read_reply %0d",
                           m_tdata[1:0], m_tuser);
                    err_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_tdata[1:0] !== want.code) begin
                        $error("cell_code: expected %0d, actual %0d", want.code, m_tdata[1:0]);
                        err_count++;
                    end
                    if (m_tuser !== want.is_read) begin
                        $error("is_read_reply: expected %0d, actual %0d", want.is_read, m_tuser);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin
        // brush setting, transaction count, idling pattern per random phase;
        // a negative radius picks one at random, 31 checks saturation
        int phase_radius[8] = '{0, 25, 31, 3, 16, 7, -1, 1};
        int phase_count[8]  = '{40, 15, 10, 40, 15, 30, 30, 30};
        int phase_mode[8]   = '{0, 0, 0, 1, 1, 1, 2, 2};
        int rad;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(36, 65);

        // Directed part, reset brush of radius 1. Grid must read back empty
        // after the clear sweep.
        push_read(0, 0);
        push_stroke(10, 10, 10, 10, BRUSH_WATER);         // single stamp
        push_read(10, 10);
        push_read(11, 10);
        push_read(11, 11);                                 // just outside the disc
        push_stroke(20, 20, 30, 25, BRUSH_SOLID);
        push_read(25, 22);
        push_stroke(40, 30, 30, 40, BRUSH_WATER);         // x runs backwards
        push_stroke(50, 10, 52, 40, BRUSH_SOLID);         // steep line
        push_read(51, 25);
        push_stroke(10, 10, 10, 10, BRUSH_ERASE);
        push_read(10, 10);
        push_stroke(20, 20, 30, 25, BRUSH_NONE);          // no stamp, writes nothing
        push_read(25, 22);
        push_stroke(-1, 0, -1, 0, BRUSH_WATER);           // center off grid, edge clipped in
        push_read(0, 0);
        push_stroke(319, 179, 330, 190, BRUSH_SOLID);     // far corner, mostly clipped
        push_read(319, 179);
        push_read(320, 179);                               // one past the last column
        push_read(-1024, -1024);
        push_read(1023, 1023);
        push_stroke(-1024, -1024, -1023, -1024, BRUSH_WATER);
        push_stroke(1023, 1023, 1022, 1023, BRUSH_SOLID);
        wait_drained();

        // Random phases, block idle between them for the register write
        for (int p = 0; p < 8; p++) begin
            case (phase_mode[p])
                0:       set_idling(36, 65);
                1:       set_idling(65, 36);
                default: set_idling(0, 0);
            endcase
            rad = (phase_radius[p] < 0) ? int'($urandom_range(0, 31)) : phase_radius[p];
            write_radius(rad);
            if (p == 6) begin
                // receiver holds off while reads pile into the command queue
                @(posedge aclk);
                hold_request <= hold_request + 1;
                repeat (8) push_read($urandom_range(0, GRID_COLS - 1),
                                     $urandom_range(0, GRID_ROWS - 1));
            end
            queue_random_items(phase_count[p], rad);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/dbls_pkg.sv
sv/dbls_front.sv
sv/dbls_cmd_fifo.sv
sv/dbls_back.sv
sv/disc_brush_line_stamper_unit.sv
verif/tb.sv
